// ===== sv/ubc_pkg.sv =====
package ubc_pkg;

  // register indexes, at byte address 4*index
  localparam int unsigned RegCyclesPerBit = 0;
  localparam int unsigned RegStartTimeout = 1;
  localparam int unsigned RegCaptureWindow = 2;

  // register reset values
  localparam logic [15:0] CyclesPerBitRst = 16'd416;
  localparam logic [31:0] StartTimeoutRst = 32'd16640;
  localparam logic [31:0] CaptureWindowRst = 32'd144000000;

  // receiver phase
  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_DATA = 4'b0010,
    PH_STOP = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // configuration seen by the receiver
  typedef struct packed {
    logic [15:0] cycles_per_bit;
    logic [31:0] start_timeout;
    logic [31:0] capture_window;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       capture_done;
    logic [8:0] bytes_captured;
  } res_t;

endpackage

// ===== sv/ubc_core.sv =====
module ubc_core
  import ubc_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  logic level,
  input  cfg_t cfg,
  output logic push,
  output res_t res
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  phase_t      phase_r, phase_nxt;
  logic [16:0] bit_timer_r, bit_timer_nxt;
  logic [31:0] idle_r, idle_nxt;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  bit_num_r, bit_num_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [31:0] window_inc;
  logic [31:0] idle_inc;
  logic [16:0] timer_inc;
  logic [16:0] target;
  logic [31:0] count_ext;
  logic [31:0] count_nxt_ext;
  logic        win_expired;

  // saturating window and idle counters, bit timer step and bit target
  assign window_inc = (window_r != '1) ? window_r + 32'd1 : window_r;
  assign idle_inc = (idle_r != '1) ? idle_r + 32'd1 : idle_r;
  assign timer_inc = bit_timer_r + 17'd1;
  assign target = (bit_num_r == 3'd0)
                ? {1'b0, cfg.cycles_per_bit} + {2'b00, cfg.cycles_per_bit[15:1]}
                : {1'b0, cfg.cycles_per_bit};
  assign win_expired = window_inc >= cfg.capture_window;
  assign count_ext = 32'(count_r);
  assign count_nxt_ext = 32'(count_r) + 32'd1;

  // per-tick receiver step
  always_comb begin
    phase_nxt = phase_r;
    bit_timer_nxt = bit_timer_r;
    idle_nxt = idle_r;
    window_nxt = window_r;
    bit_num_nxt = bit_num_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    push = 1'b0;
    res = '0;
    if (take && phase_r != PH_DONE) begin
      window_nxt = window_inc;
      case (phase_r)
        PH_WAIT: begin
          if (!level) begin
            phase_nxt = PH_DATA;
            bit_timer_nxt = '0;
            bit_num_nxt = '0;
            shift_nxt = '0;
          end else if (idle_inc > cfg.start_timeout) begin
            idle_nxt = '0;
            if (win_expired || count_r >= CW'(CAPACITY)) begin
              phase_nxt = PH_DONE;
              push = 1'b1;
              res.capture_done = 1'b1;
              res.bytes_captured = count_ext[8:0];
            end
          end else begin
            idle_nxt = idle_inc;
          end
        end
        PH_DATA: begin
          if (timer_inc >= target) begin
            bit_timer_nxt = '0;
            shift_nxt = shift_r | (8'(level) << bit_num_r);
            bit_num_nxt = bit_num_r + 3'd1;
            if (bit_num_r == 3'd7) begin
              phase_nxt = PH_STOP;
            end
          end else begin
            bit_timer_nxt = timer_inc;
          end
        end
        PH_STOP: begin
          if (timer_inc >= {1'b0, cfg.cycles_per_bit}) begin
            bit_timer_nxt = '0;
            idle_nxt = '0;
            count_nxt = count_r + CW'(1);
            push = 1'b1;
            res.byte_valid = 1'b1;
            res.byte_value = shift_r;
            res.byte_index = count_ext[7:0];
            if (win_expired || count_nxt >= CW'(CAPACITY)) begin
              phase_nxt = PH_DONE;
              res.capture_done = 1'b1;
              res.bytes_captured = count_nxt_ext[8:0];
            end else begin
              phase_nxt = PH_WAIT;
            end
          end else begin
            bit_timer_nxt = timer_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      bit_timer_r <= '0;
      idle_r <= '0;
      window_r <= '0;
      bit_num_r <= '0;
      shift_r <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      bit_timer_r <= bit_timer_nxt;
      idle_r <= idle_nxt;
      window_r <= window_nxt;
      bit_num_r <= bit_num_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/uart_byte_capture.sv =====
// 8N1 serial byte capture. Each input beat is one sample of the line, and one
// beat is taken per clock cycle while the input side does not stall. A beat
// is held in the input register, the receiver steps on it, and any result
// lands in the output register, or in its skid stage when that register holds
// a result that is not taken, and is offered from there. The input side
// stalls only when the output register and its skid stage both hold untaken
// results. Capture ends when the window expires or CAPACITY bytes are held;
// the block then flags done once and ignores samples until reset.
module uart_byte_capture
  import ubc_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_byte_index,
  output logic        out_capture_done,
  output logic [8:0]  out_bytes_captured,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  logic in_v_r;
  logic level_r;
  logic core_take;
  logic push;
  res_t res;
  res_t main_r;
  res_t skid_r;
  logic main_v_r;
  logic skid_v_r;
  logic pop;
  logic wr_en;

  // config registers
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycles_per_bit <= CyclesPerBitRst;
      cfg_r.start_timeout <= StartTimeoutRst;
      cfg_r.capture_window <= CaptureWindowRst;
    end else if (wr_en) begin
      case (32'(paddr[3:2]))
        RegCyclesPerBit:  cfg_r.cycles_per_bit <= pwdata[15:0];
        RegStartTimeout:  cfg_r.start_timeout <= pwdata;
        RegCaptureWindow: cfg_r.capture_window <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (32'(paddr[3:2]))
      RegCyclesPerBit:  prdata = {16'd0, cfg_r.cycles_per_bit};
      RegStartTimeout:  prdata = cfg_r.start_timeout;
      RegCaptureWindow: prdata = cfg_r.capture_window;
      default:          prdata = '0;
    endcase
  end

  // input register
  assign core_take = in_v_r & ~skid_v_r;
  assign in_ready = ~in_v_r | core_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= (in_valid & in_ready) | (in_v_r & ~core_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r <= in_line_level;
    end
  end

  // receiver
  ubc_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (core_take),
    .level (level_r),
    .cfg   (cfg_r),
    .push  (push),
    .res   (res)
  );

  // output register with skid stage
  assign pop = main_v_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

  // result beat
  assign out_valid = main_v_r;
  assign out_byte_valid = main_r.byte_valid;
  assign out_byte_value = main_r.byte_value;
  assign out_byte_index = main_r.byte_index;
  assign out_capture_done = main_r.capture_done;
  assign out_bytes_captured = main_r.bytes_captured;

endmodule
